/* hdl/jpeg_marker_segment_parser_assert.svh */
// assertion macros for the marker segment parser
// each macro expects clk and rst in the scope where it is used
`ifndef JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH

`ifndef SYNTH
`define JMSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jmsp: same-cycle check failed");
`define JMSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jmsp: next-cycle check failed");
`else
`define JMSP_ASSERT_IMPL(lbl, ante, cons)
`define JMSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/jmsp_pkg.sv */
`timescale 1ns / 1ps

package jmsp_pkg;

  // limits and sizes
  localparam int unsigned MAX_SEGMENTS = 20;
  localparam int unsigned KEPT_W       = 5;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // byte codes
  localparam logic [7:0]  BYTE_FF   = 8'hFF;
  localparam logic [7:0]  CODE_SOI  = 8'hD8;
  localparam logic [7:0]  CODE_EOI  = 8'hD9;
  localparam logic [7:0]  CODE_SOS  = 8'hDA;
  localparam logic [7:0]  CODE_COM  = 8'hFE;
  localparam logic [7:0]  CODE_APP1 = 8'hE1;
  localparam logic [2:0]  PAD_MAX   = 3'd6;
  localparam logic [15:0] LEN_MIN   = 16'd2;
  localparam logic [2:0]  TAG_LEN   = 3'd4;
  localparam logic [2:0]  FRAME_LEN = 3'd6;

  typedef enum logic [1:0] {
    EV_KEPT    = 2'd0,
    EV_DISCARD = 2'd1,
    EV_SCAN    = 2'd2,
    EV_ERROR   = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_SOI   = 3'd1,
    ERR_TOO_MANY = 3'd2,
    ERR_PADDING  = 3'd3,
    ERR_BAD_LEN  = 3'd4,
    ERR_EARLY    = 3'd5,
    ERR_NO_IMAGE = 3'd6
  } err_t;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_SOI_FF   = 8'b0000_0010,
    PH_SOI_CODE = 8'b0000_0100,
    PH_MARK     = 8'b0000_1000,
    PH_LEN_HI   = 8'b0001_0000,
    PH_LEN_LO   = 8'b0010_0000,
    PH_BODY     = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  // classified input word
  typedef struct packed {
    logic       start;
    logic       eof;
    logic [7:0] data;
    logic       is_ff;
    logic       is_soi;
    logic       is_sof;
  } item_t;

  // one result word
  typedef struct packed {
    event_t             ev;
    err_t               err;
    logic [7:0]         marker;
    logic [15:0]        seg_len;
    logic [31:0]        seg_off;
    logic               frame_hdr;
    logic [7:0]         precision;
    logic [15:0]        height;
    logic [15:0]        width;
    logic [7:0]         comps;
    logic               color;
    logic [KEPT_W-1:0]  kept;
  } result_t;

  // start-of-frame codes: C0..CF except DHT, JPG and DAC
  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && !((m[1:0] == 2'b00) && (m[3:2] != 2'b00));
  endfunction

  // the four tag letters of an exif body
  function automatic logic [7:0] exif_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h45;
      2'd1: c = 8'h78;
      2'd2: c = 8'h69;
      2'd3: c = 8'h66;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/jmsp_front.sv */
`timescale 1ns / 1ps

module jmsp_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            start_of_file,
  input  logic [7:0]      data_byte,
  input  logic            end_of_file,
  input  logic            q_full,
  output logic            push,
  output jmsp_pkg::item_t item
);

  // take a word whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the byte ahead of the parser
  always_comb begin
    item.start  = start_of_file;
    item.eof    = end_of_file;
    item.data   = data_byte;
    item.is_ff  = (data_byte == jmsp_pkg::BYTE_FF);
    item.is_soi = (data_byte == jmsp_pkg::CODE_SOI);
    item.is_sof = jmsp_pkg::is_sof(data_byte);
  end

endmodule

/* hdl/jmsp_queue.sv */
`timescale 1ns / 1ps

module jmsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jmsp_pkg::item_t push_item,
  input  logic            pop,
  output jmsp_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  jmsp_pkg::item_t                   slots [jmsp_pkg::QUEUE_DEPTH];
  logic [jmsp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [jmsp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [jmsp_pkg::QCNT_W-1:0]       count;

  assign full  = (count == jmsp_pkg::QCNT_W'(jmsp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/jmsp_back.sv */
`timescale 1ns / 1ps

module jmsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  jmsp_pkg::item_t   q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output jmsp_pkg::result_t res
);

  // parser state
  jmsp_pkg::phase_t              phase;
  logic [2:0]                    pad;
  logic [jmsp_pkg::KEPT_W-1:0]   kept;
  logic                          com_seen;
  logic [7:0]                    marker;
  logic                          marker_sof;
  logic [7:0]                    len_hi;
  logic [15:0]                   len;
  logic [15:0]                   left;
  logic [2:0]                    bidx;
  logic                          exif_ok;
  logic [31:0]                   offset;
  logic [31:0]                   start_off;
  logic [7:0]                    f_prec;
  logic [15:0]                   f_height;
  logic [15:0]                   f_width;
  logic [7:0]                    f_comps;

  // state after an optional restart
  jmsp_pkg::phase_t              c_phase;
  logic [2:0]                    c_pad;
  logic [jmsp_pkg::KEPT_W-1:0]   c_kept;
  logic                          c_com_seen;
  logic [7:0]                    c_marker;
  logic                          c_marker_sof;
  logic [7:0]                    c_len_hi;
  logic [15:0]                   c_len;
  logic [15:0]                   c_left;
  logic [2:0]                    c_bidx;
  logic                          c_exif_ok;
  logic [31:0]                   c_offset;
  logic [31:0]                   c_start_off;
  logic [7:0]                    c_prec;
  logic [15:0]                   c_height;
  logic [15:0]                   c_width;
  logic [7:0]                    c_comps;

  jmsp_pkg::phase_t              phase_next;
  logic [2:0]                    pad_next;
  logic [jmsp_pkg::KEPT_W-1:0]   kept_next;
  logic                          com_seen_next;
  logic [7:0]                    marker_next;
  logic                          marker_sof_next;
  logic [7:0]                    len_hi_next;
  logic [15:0]                   len_next;
  logic [15:0]                   left_next;
  logic [2:0]                    bidx_next;
  logic                          exif_ok_next;
  logic [31:0]                   offset_next;
  logic [31:0]                   start_off_next;
  logic [7:0]                    f_prec_next;
  logic [15:0]                   f_height_next;
  logic [15:0]                   f_width_next;
  logic [7:0]                    f_comps_next;

  logic                          has_res;
  logic                          finish;
  logic                          seg;
  logic                          frame;
  jmsp_pkg::event_t              ev;
  jmsp_pkg::err_t                err;
  jmsp_pkg::result_t             res_next;

  // take the next word whenever the result register is free or draining
  assign pop = !q_empty && (!out_valid || !out_stall);

  // restart view of the state
  always_comb begin
    c_phase      = phase;
    c_pad        = pad;
    c_kept       = kept;
    c_com_seen   = com_seen;
    c_marker     = marker;
    c_marker_sof = marker_sof;
    c_len_hi     = len_hi;
    c_len        = len;
    c_left       = left;
    c_bidx       = bidx;
    c_exif_ok    = exif_ok;
    c_offset     = offset;
    c_start_off  = start_off;
    c_prec       = f_prec;
    c_height     = f_height;
    c_width      = f_width;
    c_comps      = f_comps;
    if (q_head.start) begin
      c_phase      = jmsp_pkg::PH_SOI_FF;
      c_pad        = '0;
      c_kept       = '0;
      c_com_seen   = 1'b0;
      c_marker     = '0;
      c_marker_sof = 1'b0;
      c_len_hi     = '0;
      c_len        = '0;
      c_left       = '0;
      c_bidx       = '0;
      c_exif_ok    = 1'b1;
      c_offset     = '0;
      c_start_off  = '0;
      c_prec       = '0;
      c_height     = '0;
      c_width      = '0;
      c_comps      = '0;
    end
  end

  // one byte step of the parser
  always_comb begin
    phase_next      = c_phase;
    pad_next        = c_pad;
    kept_next       = c_kept;
    com_seen_next   = c_com_seen;
    marker_next     = c_marker;
    marker_sof_next = c_marker_sof;
    len_hi_next     = c_len_hi;
    len_next        = c_len;
    left_next       = c_left;
    bidx_next       = c_bidx;
    exif_ok_next    = c_exif_ok;
    offset_next     = c_offset;
    start_off_next  = c_start_off;
    f_prec_next     = c_prec;
    f_height_next   = c_height;
    f_width_next    = c_width;
    f_comps_next    = c_comps;
    has_res         = 1'b0;
    finish          = 1'b0;
    seg             = 1'b0;
    frame           = 1'b0;
    ev              = jmsp_pkg::EV_ERROR;
    err             = jmsp_pkg::ERR_NONE;

    // byte offset, held at all ones
    if (c_phase != jmsp_pkg::PH_IDLE && c_phase != jmsp_pkg::PH_DONE &&
        !q_head.eof && c_offset != '1) begin
      offset_next = c_offset + 32'd1;
    end

    unique case (c_phase)
      jmsp_pkg::PH_SOI_FF: begin
        if (q_head.eof || !q_head.is_ff) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_NO_SOI;
        end else begin
          phase_next = jmsp_pkg::PH_SOI_CODE;
        end
      end
      jmsp_pkg::PH_SOI_CODE: begin
        if (q_head.eof || !q_head.is_soi) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_NO_SOI;
        end else begin
          phase_next = jmsp_pkg::PH_MARK;
          pad_next   = '0;
        end
      end
      jmsp_pkg::PH_MARK: begin
        if (c_kept >= jmsp_pkg::KEPT_W'(jmsp_pkg::MAX_SEGMENTS)) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_TOO_MANY;
        end else if (q_head.eof) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_EARLY;
        end else if (q_head.is_ff) begin
          if (c_pad >= jmsp_pkg::PAD_MAX) begin
            has_res = 1'b1;
            err     = jmsp_pkg::ERR_PADDING;
          end else begin
            pad_next = c_pad + 3'd1;
          end
        end else begin
          marker_next     = q_head.data;
          marker_sof_next = q_head.is_sof;
          pad_next        = '0;
          phase_next      = jmsp_pkg::PH_LEN_HI;
        end
      end
      jmsp_pkg::PH_LEN_HI: begin
        if (q_head.eof) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_EARLY;
        end else begin
          start_off_next = c_offset;
          len_hi_next    = q_head.data;
          phase_next     = jmsp_pkg::PH_LEN_LO;
        end
      end
      jmsp_pkg::PH_LEN_LO: begin
        if (q_head.eof) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_EARLY;
        end else begin
          len_next = {c_len_hi, q_head.data};
          if (len_next < jmsp_pkg::LEN_MIN) begin
            has_res = 1'b1;
            err     = jmsp_pkg::ERR_BAD_LEN;
          end else begin
            left_next    = len_next - jmsp_pkg::LEN_MIN;
            bidx_next    = '0;
            exif_ok_next = 1'b1;
            if (c_marker_sof) begin
              f_prec_next   = '0;
              f_height_next = '0;
              f_width_next  = '0;
              f_comps_next  = '0;
            end
            if (len_next == jmsp_pkg::LEN_MIN) begin
              finish = 1'b1;
            end else begin
              phase_next = jmsp_pkg::PH_BODY;
            end
          end
        end
      end
      jmsp_pkg::PH_BODY: begin
        if (q_head.eof) begin
          has_res = 1'b1;
          err     = jmsp_pkg::ERR_EARLY;
        end else begin
          // exif tag check over the first four body bytes
          if (c_marker == jmsp_pkg::CODE_APP1 && c_bidx < jmsp_pkg::TAG_LEN &&
              q_head.data != jmsp_pkg::exif_char(c_bidx[1:0])) begin
            exif_ok_next = 1'b0;
          end
          // frame header capture
          if (c_marker_sof) begin
            unique case (c_bidx)
              3'd0: f_prec_next         = q_head.data;
              3'd1: f_height_next[15:8] = q_head.data;
              3'd2: f_height_next[7:0]  = q_head.data;
              3'd3: f_width_next[15:8]  = q_head.data;
              3'd4: f_width_next[7:0]   = q_head.data;
              3'd5: f_comps_next        = q_head.data;
              default: ;
            endcase
          end
          if (c_bidx < jmsp_pkg::FRAME_LEN) begin
            bidx_next = c_bidx + 3'd1;
          end
          left_next = c_left - 16'd1;
          if (c_left == 16'd1) begin
            finish = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // errors end the parse
    if (has_res) begin
      phase_next = jmsp_pkg::PH_DONE;
      ev         = jmsp_pkg::EV_ERROR;
    end

    // segment completion and its classification
    if (finish) begin
      has_res    = 1'b1;
      seg        = 1'b1;
      pad_next   = '0;
      phase_next = jmsp_pkg::PH_MARK;
      kept_next  = c_kept + 1'b1;
      ev         = jmsp_pkg::EV_KEPT;
      priority if (c_marker == jmsp_pkg::CODE_SOS) begin
        phase_next = jmsp_pkg::PH_DONE;
        ev         = jmsp_pkg::EV_SCAN;
      end else if (c_marker == jmsp_pkg::CODE_EOI) begin
        phase_next = jmsp_pkg::PH_DONE;
        ev         = jmsp_pkg::EV_ERROR;
        err        = jmsp_pkg::ERR_NO_IMAGE;
      end else if (c_marker == jmsp_pkg::CODE_COM) begin
        if (c_com_seen) begin
          kept_next = c_kept;
          ev        = jmsp_pkg::EV_DISCARD;
        end else begin
          com_seen_next = 1'b1;
        end
      end else if (c_marker == jmsp_pkg::CODE_APP1) begin
        if (!(exif_ok_next && bidx_next >= jmsp_pkg::TAG_LEN)) begin
          kept_next = c_kept;
          ev        = jmsp_pkg::EV_DISCARD;
        end
      end else begin
        frame = c_marker_sof;
      end
    end
  end

  // result word
  always_comb begin
    res_next.ev        = ev;
    res_next.err       = err;
    res_next.marker    = seg ? marker_next : '0;
    res_next.seg_len   = seg ? len_next : '0;
    res_next.seg_off   = seg ? start_off_next : '0;
    res_next.frame_hdr = frame;
    res_next.precision = f_prec_next;
    res_next.height    = f_height_next;
    res_next.width     = f_width_next;
    res_next.comps     = f_comps_next;
    res_next.color     = (f_comps_next == 8'd3);
    res_next.kept      = kept_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jmsp_pkg::PH_IDLE;
    end else if (pop) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pad        <= pad_next;
      kept       <= kept_next;
      com_seen   <= com_seen_next;
      marker     <= marker_next;
      marker_sof <= marker_sof_next;
      len_hi     <= len_hi_next;
      len        <= len_next;
      left       <= left_next;
      bidx       <= bidx_next;
      exif_ok    <= exif_ok_next;
      offset     <= offset_next;
      start_off  <= start_off_next;
      f_prec     <= f_prec_next;
      f_height   <= f_height_next;
      f_width    <= f_width_next;
      f_comps    <= f_comps_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= pop && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      res <= res_next;
    end
  end

endmodule

/* hdl/jpeg_marker_segment_parser.sv */
`timescale 1ns / 1ps

// JPEG marker segment parser. Takes one file byte (or an end-of-file mark) per
// cycle unless stalled and, after the SOI check, walks the marker segments,
// giving one result word for each finished segment and for each error. A new
// byte is accepted every cycle while the four-word queue between the byte
// classifier and the parser state machine has room; the parser drains one word
// per cycle when its result register is free or being taken, so sustained rate
// is one byte per cycle while out_stall is low. A result is registered as its
// byte leaves the queue. Assert start_of_file on the first byte of each file.

`include "jpeg_marker_segment_parser_assert.svh"

module jpeg_marker_segment_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_of_file,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [2:0]  error_code,
  output logic [7:0]  marker_code,
  output logic [15:0] segment_length,
  output logic [31:0] segment_offset,
  output logic        is_frame_header,
  output logic [7:0]  sample_precision,
  output logic [15:0] image_height,
  output logic [15:0] image_width,
  output logic [7:0]  component_count,
  output logic        is_color,
  output logic [4:0]  segments_kept
);

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  jmsp_pkg::item_t    push_item;
  jmsp_pkg::item_t    q_head;
  jmsp_pkg::result_t  res;

  // byte classifier
  jmsp_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_of_file (start_of_file),
    .data_byte     (data_byte),
    .end_of_file   (end_of_file),
    .q_full        (q_full),
    .push          (push),
    .item          (push_item)
  );

  // decoupling queue
  jmsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // segment parser
  jmsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // result fields
  assign event_res        = res.ev;
  assign error_code       = res.err;
  assign marker_code      = res.marker;
  assign segment_length   = res.seg_len;
  assign segment_offset   = res.seg_off;
  assign is_frame_header  = res.frame_hdr;
  assign sample_precision = res.precision;
  assign image_height     = res.height;
  assign image_width      = res.width;
  assign component_count  = res.comps;
  assign is_color         = res.color;
  assign segments_kept    = res.kept;

  // checks
  `JMSP_ASSERT_IMPL(a_err_has_code, out_valid && event_res == jmsp_pkg::EV_ERROR,
                    error_code != jmsp_pkg::ERR_NONE)
  `JMSP_ASSERT_IMPL(a_ok_no_code, out_valid && event_res != jmsp_pkg::EV_ERROR,
                    error_code == jmsp_pkg::ERR_NONE)
  `JMSP_ASSERT_IMPL(a_kept_limit, out_valid, segments_kept <= 5'(jmsp_pkg::MAX_SEGMENTS))
  `JMSP_ASSERT_IMPL(a_frame_kept, out_valid && is_frame_header, event_res == jmsp_pkg::EV_KEPT)
  `JMSP_ASSERT_NEXT(a_pop_needs_word, pop, !$past(q_empty))

endmodule

/* tb/sv/segment_tracker_pkg.sv */
`timescale 1ns / 1ps

package segment_tracker_pkg;
  import jmsp_pkg::*;

  // marker codes and values the bench needs beyond the design package
  localparam logic [7:0]  CODE_APP0    = 8'hE0;
  localparam logic [7:0]  CODE_DQT     = 8'hDB;
  localparam logic [7:0]  CODE_DHT     = 8'hC4;
  localparam logic [7:0]  CODE_JPG     = 8'hC8;
  localparam logic [7:0]  CODE_DAC     = 8'hCC;
  localparam logic [7:0]  SOF_FIRST    = 8'hC0;
  localparam logic [7:0]  SOF_LAST     = 8'hCF;
  localparam logic [31:0] EXIF_TAG     = 32'h4578_6966;
  localparam logic [7:0]  COLOUR_COMPS = 8'd3;
  localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;

  class segment_tracker;
    result_t     awaited_words[$];
    int          failures;

    // parser state as the block should hold it
    phase_t      phase;
    int unsigned pad_run;
    int unsigned kept;
    bit          com_seen;
    logic [7:0]  marker;
    logic [7:0]  len_hi;
    logic [15:0] seg_len;
    logic [15:0] body_left;
    int unsigned body_pos;
    bit          tag_ok;
    logic [31:0] offset;
    logic [31:0] seg_start;
    logic [7:0]  prec;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  comps;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      phase     = PH_IDLE;
      pad_run   = 0;
      kept      = 0;
      com_seen  = 1'b0;
      marker    = '0;
      len_hi    = '0;
      seg_len   = '0;
      body_left = '0;
      body_pos  = 0;
      tag_ok    = 1'b1;
      offset    = '0;
      seg_start = '0;
      prec      = '0;
      height    = '0;
      width     = '0;
      comps     = '0;
    endfunction

    // start-of-frame range less the DHT, JPG and DAC codes
    function bit frame_marker(logic [7:0] m);
      return m >= SOF_FIRST && m <= SOF_LAST && m != CODE_DHT && m != CODE_JPG &&
             m != CODE_DAC;
    endfunction

    function void post(event_t ev, err_t err, bit with_seg, bit frame);
      result_t r;
      r.ev        = ev;
      r.err       = err;
      r.marker    = with_seg ? marker : '0;
      r.seg_len   = with_seg ? seg_len : '0;
      r.seg_off   = with_seg ? seg_start : '0;
      r.frame_hdr = frame;
      r.precision = prec;
      r.height    = height;
      r.width     = width;
      r.comps     = comps;
      r.color     = (comps == COLOUR_COMPS);
      r.kept      = kept[KEPT_W-1:0];
      awaited_words.push_back(r);
    endfunction

    function void abort(err_t err);
      phase = PH_DONE;
      post(EV_ERROR, err, 1'b0, 1'b0);
    endfunction

    // end of a segment body: scan, image end, discard or keep
    function void close_segment();
      kept++;
      phase   = PH_MARK;
      pad_run = 0;
      if (marker == CODE_SOS) begin
        phase = PH_DONE;
        post(EV_SCAN, ERR_NONE, 1'b1, 1'b0);
      end else if (marker == CODE_EOI) begin
        phase = PH_DONE;
        post(EV_ERROR, ERR_NO_IMAGE, 1'b1, 1'b0);
      end else if (marker == CODE_COM && com_seen) begin
        kept--;
        post(EV_DISCARD, ERR_NONE, 1'b1, 1'b0);
      end else if (marker == CODE_COM) begin
        com_seen = 1'b1;
        post(EV_KEPT, ERR_NONE, 1'b1, 1'b0);
      end else if (marker == CODE_APP1 && !(tag_ok && body_pos >= 4)) begin
        kept--;
        post(EV_DISCARD, ERR_NONE, 1'b1, 1'b0);
      end else begin
        post(EV_KEPT, ERR_NONE, 1'b1, frame_marker(marker));
      end
    endfunction

    // one accepted input word
    function void take_byte(logic sof, logic [7:0] b, logic eof);
      logic [31:0] here;
      if (sof) begin
        clear();
        phase = PH_SOI_FF;
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;
      here = offset;
      if (!eof && offset != OFFSET_MAX) offset++;
      case (phase)
        PH_SOI_FF: begin
          if (eof || b != BYTE_FF) abort(ERR_NO_SOI);
          else phase = PH_SOI_CODE;
        end
        PH_SOI_CODE: begin
          if (eof || b != CODE_SOI) abort(ERR_NO_SOI);
          else begin
            phase   = PH_MARK;
            pad_run = 0;
          end
        end
        PH_MARK: begin
          if (kept >= MAX_SEGMENTS) abort(ERR_TOO_MANY);
          else if (eof) abort(ERR_EARLY);
          else if (b == BYTE_FF) begin
            if (pad_run >= PAD_MAX) abort(ERR_PADDING);
            else pad_run++;
          end else begin
            marker  = b;
            pad_run = 0;
            phase   = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          if (eof) abort(ERR_EARLY);
          else begin
            seg_start = here;
            len_hi    = b;
            phase     = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (eof) abort(ERR_EARLY);
          else begin
            seg_len = {len_hi, b};
            if (seg_len < LEN_MIN) abort(ERR_BAD_LEN);
            else begin
              body_left = seg_len - LEN_MIN;
              body_pos  = 0;
              tag_ok    = 1'b1;
              if (frame_marker(marker)) begin
                prec   = '0;
                height = '0;
                width  = '0;
                comps  = '0;
              end
              if (body_left == 0) close_segment();
              else phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (eof) abort(ERR_EARLY);
          else begin
            if (marker == CODE_APP1 && body_pos < 4 && b != EXIF_TAG[31 - 8*body_pos -: 8])
              tag_ok = 1'b0;
            if (frame_marker(marker)) begin
              case (body_pos)
                0: prec = b;
                1: height[15:8] = b;
                2: height[7:0] = b;
                3: width[15:8] = b;
                4: width[7:0] = b;
                5: comps = b;
                default: ;
              endcase
            end
            if (body_pos < 6) body_pos++;
            body_left--;
            if (body_left == 0) close_segment();
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // one accepted result word against the oldest awaited one
    function void check_segment(result_t got);
      result_t want;
      if (awaited_words.size() == 0) begin
        failures++;
        $error("result word with none awaited: event %0d error %0d marker %0h",
               got.ev, got.err, got.marker);
        return;
      end
      want = awaited_words.pop_front();
      compare_field("event_res", want.ev, got.ev);
      compare_field("error_code", want.err, got.err);
      compare_field("marker_code", want.marker, got.marker);
      compare_field("segment_length", want.seg_len, got.seg_len);
      compare_field("segment_offset", want.seg_off, got.seg_off);
      compare_field("is_frame_header", want.frame_hdr, got.frame_hdr);
      compare_field("sample_precision", want.precision, got.precision);
      compare_field("image_height", want.height, got.height);
      compare_field("image_width", want.width, got.width);
      compare_field("component_count", want.comps, got.comps);
      compare_field("is_color", want.color, got.color);
      compare_field("segments_kept", want.kept, got.kept);
    endfunction
  endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import jmsp_pkg::*;
  import segment_tracker_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 1250;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        start_of_file = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [2:0]  error_code;
  logic [7:0]  marker_code;
  logic [15:0] segment_length;
  logic [31:0] segment_offset;
  logic        is_frame_header;
  logic [7:0]  sample_precision;
  logic [15:0] image_height;
  logic [15:0] image_width;
  logic [7:0]  component_count;
  logic        is_color;
  logic [4:0]  segments_kept;

  segment_tracker tracker;
  result_t        seen_word;
  logic [7:0]     file_q[$];
  int             sent_items = 0;
  int             idle_cycles = 0;
  bit             gaps_on = 1'b1;
  bit             stalls_on = 1'b1;
  bit             long_hold = 1'b0;
  bit             hold_done = 1'b0;

  jpeg_marker_segment_parser u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .start_of_file    (start_of_file),
    .data_byte        (data_byte),
    .end_of_file      (end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_res        (event_res),
    .error_code       (error_code),
    .marker_code      (marker_code),
    .segment_length   (segment_length),
    .segment_offset   (segment_offset),
    .is_frame_header  (is_frame_header),
    .sample_precision (sample_precision),
    .image_height     (image_height),
    .image_width      (image_width),
    .component_count  (component_count),
    .is_color         (is_color),
    .segments_kept    (segments_kept)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // offer one input word, with an occasional gap before it
  task automatic send_word(input logic sof, input logic [7:0] b, input logic eof);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    start_of_file <= sof;
    data_byte     <= b;
    end_of_file   <= eof;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(sof, b, eof);
    sent_items++;
  endtask

  // send the first bytes of the built file, start flag on the first
  task automatic play_file(input int upto);
    for (int i = 0; i < upto; i++) send_word(i == 0, file_q[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_marker();
    logic [7:0] m;
    case ($urandom_range(0, 9))
      0, 1:    m = CODE_APP0 + 8'($urandom_range(0, 15));
      2:       m = CODE_COM;
      3, 4:    m = CODE_APP1;
      5, 6:    m = SOF_FIRST + 8'($urandom_range(0, 15));
      7:       m = CODE_DQT;
      default: m = 8'($urandom_range(0, 254));
    endcase
    return m;
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'($urandom_range(0, 1));
    if (r < 8) return 16'($urandom_range(2, 300));
    return 16'($urandom_range(2, 14));
  endfunction

  function automatic int pick_padding();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 80) return 1;
    if (r < 95) return $urandom_range(2, 6);
    return 7;
  endfunction

  // append one segment: padding, code, length and a body to match
  task automatic push_segment(input logic [7:0] code, input logic [15:0] len, input int pad);
    logic [7:0] v;
    int         body_len;
    bit         tag_body;
    body_len = (len >= LEN_MIN) ? len - LEN_MIN : 0;
    tag_body = ($urandom_range(0, 9) < 7);
    repeat (pad) file_q.push_back(BYTE_FF);
    file_q.push_back(code);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    for (int i = 0; i < body_len; i++) begin
      v = 8'($urandom_range(0, 255));
      if (code == CODE_APP1 && tag_body && i < 4) v = EXIF_TAG[31 - 8*i -: 8];
      if (code >= SOF_FIRST && code <= SOF_LAST && i == 5 && $urandom_range(0, 1) == 1)
        v = COLOUR_COMPS;
      file_q.push_back(v);
    end
  endtask

  // one random file: mostly well formed, sometimes cut short or corrupted
  task automatic send_random_file();
    int n_seg;
    int ending;
    int cut;
    file_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      file_q.push_back(8'($urandom_range(0, 255)));
      file_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      file_q.push_back(BYTE_FF);
      file_q.push_back(CODE_SOI);
    end
    n_seg = ($urandom_range(0, 6) == 0) ? $urandom_range(19, 24) : $urandom_range(0, 8);
    for (int s = 0; s < n_seg; s++) push_segment(pick_marker(), pick_length(), pick_padding());
    ending = $urandom_range(0, 9);
    if (ending < 5) push_segment(CODE_SOS, pick_length(), 1);
    else if (ending < 7) push_segment(CODE_EOI, pick_length(), 1);
    if ($urandom_range(0, 9) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
    cut = file_q.size();
    if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, file_q.size());
    play_file(cut);
    if (ending == 9 || cut < file_q.size())
      send_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    // stray words after the file has ended
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // receiver: random stall bursts and one long hold-off
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word.ev        = event_t'(event_res);
      seen_word.err       = err_t'(error_code);
      seen_word.marker    = marker_code;
      seen_word.seg_len   = segment_length;
      seen_word.seg_off   = segment_offset;
      seen_word.frame_hdr = is_frame_header;
      seen_word.precision = sample_precision;
      seen_word.height    = image_height;
      seen_word.width     = image_width;
      seen_word.comps     = component_count;
      seen_word.color     = is_color;
      seen_word.kept      = segments_kept;
      tracker.check_segment(seen_word);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // byte before any file start is ignored
    send_word(1'b0, 8'h00, 1'b0);
    // wrong start code, then a word after the parse has ended
    file_q = '{BYTE_FF, CODE_EOI, 8'h55};
    play_file(file_q.size());
    // end of file on the very first word
    send_word(1'b1, 8'hA5, 1'b1);
    // full frame header at its extremes, then scan start
    file_q = '{BYTE_FF, CODE_SOI, BYTE_FF, SOF_FIRST, 8'h00, 8'h08, 8'hFF, 8'hFF, 8'hFF,
               8'hFF, 8'hFF, COLOUR_COMPS, BYTE_FF, CODE_SOS, 8'h00, 8'h02};
    play_file(file_q.size());
    // short frame header with no prefix byte, then too much padding
    file_q = '{BYTE_FF, CODE_SOI, SOF_FIRST + 8'd1, 8'h00, 8'h05, 8'h0C, 8'h01, 8'h02,
               BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF};
    play_file(file_q.size());
    // short app1 is discarded, then a length below two
    file_q = '{BYTE_FF, CODE_SOI, CODE_APP1, 8'h00, 8'h03, 8'h45, 8'h00, 8'h00, 8'h01};
    play_file(file_q.size());
    // image end before any scan
    file_q = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_EOI, 8'h00, 8'h02};
    play_file(file_q.size());
    // file ends while waiting for a marker
    file_q = '{BYTE_FF, CODE_SOI, BYTE_FF};
    play_file(file_q.size());
    send_word(1'b0, 8'h00, 1'b1);

    // random files, with gap-free and stall-free stretches in the middle and at the end
    while (sent_items < ITEM_TARGET) begin
      gaps_on   = !(sent_items >= 500 && sent_items < 650) && sent_items < 1050;
      stalls_on = gaps_on;
      if (!hold_done && sent_items > 350) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      send_random_file();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (tracker.awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.awaited_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/jmsp_pkg.sv
hdl/jmsp_front.sv
hdl/jmsp_queue.sv
hdl/jmsp_back.sv
hdl/jpeg_marker_segment_parser.sv
tb/sv/segment_tracker_pkg.sv
tb/sv/testbench.sv
